// ===== rtl/mhpq_pkg.sv =====
// mhpq_pkg: shared types, widths and codes of the min-heap priority queue
// no dependencies; imported by the engine, the top level and the bench, not by mhpq_ram
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

	localparam int DEPTH = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 11;
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic opcode;
		logic signed [31:0] key;
		logic [31:0] payload;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] out_key;
		logic [31:0] out_payload;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [31:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic idle;
		logic [CNT_W-1:0] count;
		logic [LIM_W-1:0] limit;
	} eng_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_FETCH,
		ST_DN_RD,
		ST_DN_CMP,
		ST_PLACE,
		ST_DONE
	} eng_state_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
// mhpq_ram: one write port, two read ports, registered read data
// generic; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
	parameter int DATA_W = 64,
	parameter int WORDS = 1024,
	parameter int ADDR_W = $clog2(WORDS)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic [DATA_W-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr_a,
	output logic [DATA_W-1:0] rdata_a,
	input wire logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/mhpq_engine.sv =====
// mhpq_engine: entry count and the sift-up / sift-down sequencer over the heap memory
// depends on mhpq_pkg; drives the ports of mhpq_ram
`timescale 1ns / 1ps
`default_nettype none

module mhpq_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_go,
	input wire mhpq_pkg::cmd_t cmd,
	input wire logic [mhpq_pkg::CAP_W-1:0] cap,
	output mhpq_pkg::rsp_t res,
	output logic res_valid,
	input wire logic res_take,
	output mhpq_pkg::eng_stat_t stat,
	output logic we,
	output logic [mhpq_pkg::ADDR_W-1:0] waddr,
	output logic [mhpq_pkg::ENTRY_W-1:0] wdata,
	output logic [mhpq_pkg::ADDR_W-1:0] raddr_a,
	input wire logic [mhpq_pkg::ENTRY_W-1:0] rdata_a,
	output logic [mhpq_pkg::ADDR_W-1:0] raddr_b,
	input wire logic [mhpq_pkg::ENTRY_W-1:0] rdata_b
);

	import mhpq_pkg::*;

	eng_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	entry_t cur_q, cur_d;
	rsp_t res_q, res_d;

	entry_t rd_a, rd_b, child;
	logic [LIM_W-1:0] cap_ext, dep_ext, limit;
	logic [CNT_W:0] two_pos, n_ext, child_pos;
	logic [CNT_W-1:0] parent;
	logic pick_right;

	assign rd_a = entry_t'(rdata_a);
	assign rd_b = entry_t'(rdata_b);

	assign cap_ext = LIM_W'(cap);
	assign dep_ext = LIM_W'(DEPTH);
	assign limit = (cap_ext > dep_ext) ? dep_ext : cap_ext;

	assign two_pos = {pos_q, 1'b0};
	assign n_ext = {1'b0, count_q};
	assign parent = pos_q >> 1;
	assign pick_right = (two_pos < n_ext) && ($signed(rd_a.key) > $signed(rd_b.key));
	assign child = pick_right ? rd_b : rd_a;
	assign child_pos = pick_right ? (two_pos + (CNT_W+1)'(1)) : two_pos;

	assign res = res_q;
	assign res_valid = (state_q == ST_DONE);
	assign stat.idle = (state_q == ST_IDLE);
	assign stat.count = count_q;
	assign stat.limit = limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		cur_q <= cur_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d = pos_q;
		cur_d = cur_q;
		res_d = res_q;
		we = 1'b0;
		waddr = ADDR_W'(pos_q - CNT_W'(1));
		wdata = cur_q;
		raddr_a = '0;
		raddr_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_go) begin
					res_d = '{status: STATUS_OK, out_key: '0, out_payload: '0};
					if (cmd.opcode == OP_PUSH) begin
						if (LIM_W'(count_q) >= limit) begin
							res_d.status = STATUS_FULL;
							state_d = ST_DONE;
						end else begin
							count_d = count_q + CNT_W'(1);
							pos_d = count_q + CNT_W'(1);
							cur_d = '{key: cmd.key, payload: cmd.payload};
							state_d = (count_q == '0) ? ST_PLACE : ST_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							res_d.status = STATUS_EMPTY;
							state_d = ST_DONE;
						end else begin
							raddr_a = '0;
							raddr_b = ADDR_W'(count_q - CNT_W'(1));
							count_d = count_q - CNT_W'(1);
							state_d = ST_DN_FETCH;
						end
					end
				end
			end
			ST_UP_RD: begin
				raddr_a = ADDR_W'(parent - CNT_W'(1));
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if ($signed(rd_a.key) > $signed(cur_q.key)) begin
					wdata = rd_a;
					pos_d = parent;
					state_d = (parent == CNT_W'(1)) ? ST_PLACE : ST_UP_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DN_FETCH: begin
				res_d.out_key = rd_a.key;
				res_d.out_payload = rd_a.payload;
				cur_d = rd_b;
				pos_d = CNT_W'(1);
				state_d = (count_q == '0) ? ST_DONE : ST_DN_RD;
			end
			ST_DN_RD: begin
				if (two_pos <= n_ext) begin
					raddr_a = ADDR_W'(two_pos - (CNT_W+1)'(1));
					raddr_b = ADDR_W'(two_pos);
					state_d = ST_DN_CMP;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if ($signed(cur_q.key) > $signed(child.key)) begin
					wdata = child;
					pos_d = CNT_W'(child_pos);
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PLACE: begin
				we = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/min_heap_priority_queue_core.sv =====
// min_heap_priority_queue_core: top level with capacity register and result register
// depends on mhpq_pkg, mhpq_ram, mhpq_engine
//
//   channel  direction  handshake            beat
//   cmd      in         cmd_valid/cmd_stall  opcode, key, payload
//   rsp      out        rsp_valid/rsp_stall  status, out_key, out_payload
//   cfg      in         cfg_valid/cfg_ready  capacity (11 bits)
//
// one command at a time; a refused push or pop goes from accept straight to ST_DONE with its status
// each heap level costs a memory read and a compare-and-write
// the result register frees the engine, which holds its result only if rsp is stalled
// arst_n empties the queue and sets capacity to 1024; the heap memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_stall,
	input wire mhpq_pkg::cmd_t cmd,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output mhpq_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [mhpq_pkg::CAP_W-1:0] cfg_data
);

	import mhpq_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	rsp_t res;
	logic res_valid, res_take, cmd_go;
	eng_stat_t stat;
	logic we;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [ENTRY_W-1:0] wdata, rdata_a, rdata_b;

	assign cfg_ready = 1'b1;
	assign cmd_stall = !stat.idle;
	assign cmd_go = cmd_valid && !cmd_stall;
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	mhpq_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_go(cmd_go),
		.cmd(cmd),
		.cap(cap_q),
		.res(res),
		.res_valid(res_valid),
		.res_take(res_take),
		.stat(stat),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	mhpq_ram #(
		.DATA_W(ENTRY_W),
		.WORDS(DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(stat.count) <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_go |=> !stat.idle)
		else $error("engine idle right after a command beat");

	a_full_only_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res.status == STATUS_FULL) |-> (LIM_W'(stat.count) >= stat.limit))
		else $error("push refused below the limit");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> (rsp_valid && !res_valid))
		else $error("result beat not moved to the output register");

endmodule

`default_nettype wire

// ===== bench/tb_min_heap_priority_queue_core.sv =====
// tb_min_heap_priority_queue_core: self-checking bench for the min-heap priority queue core
// a shadow heap in a scoreboard class predicts every rsp beat; tasks drive cmd and cfg, a process drives rsp stalls
// depends on mhpq_pkg and min_heap_priority_queue_core
`timescale 1ns / 1ps

import mhpq_pkg::*;

class pq_scoreboard;
	entry_t shadow_heap [1:DEPTH];
	int unsigned shadow_count;
	logic [CAP_W-1:0] shadow_cap;
	rsp_t rsp_due [$];
	int unsigned errors;
	int unsigned n_push, n_full, n_pop, n_empty, peak_count;

	function new();
		shadow_count = 0;
		shadow_cap = CAP_RESET;
		errors = 0;
		n_push = 0;
		n_full = 0;
		n_pop = 0;
		n_empty = 0;
		peak_count = 0;
	endfunction

	function void set_capacity(logic [CAP_W-1:0] value);
		shadow_cap = value;
	endfunction

	function bit heavier(entry_t a, entry_t b);
		return $signed(a.key) > $signed(b.key);
	endfunction

	function void bubble_up(int unsigned pos);
		entry_t t;
		while (pos > 1 && heavier(shadow_heap[pos / 2], shadow_heap[pos])) begin
			t = shadow_heap[pos / 2];
			shadow_heap[pos / 2] = shadow_heap[pos];
			shadow_heap[pos] = t;
			pos = pos / 2;
		end
	endfunction

	function void bubble_down(int unsigned n);
		int unsigned pos;
		int unsigned child;
		entry_t t;
		pos = 1;
		while (2 * pos <= n) begin
			child = 2 * pos;
			if (child < n && heavier(shadow_heap[child], shadow_heap[child + 1]))
				child++;
			if (!heavier(shadow_heap[pos], shadow_heap[child]))
				break;
			t = shadow_heap[pos];
			shadow_heap[pos] = shadow_heap[child];
			shadow_heap[child] = t;
			pos = child;
		end
	endfunction

	function void note_cmd(cmd_t c);
		rsp_t r;
		int unsigned lim;
		r = '0;
		lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
		if (c.opcode == OP_PUSH) begin
			if (shadow_count >= lim) begin
				r.status = STATUS_FULL;
				n_full++;
			end else begin
				r.status = STATUS_OK;
				shadow_count++;
				shadow_heap[shadow_count].key = c.key;
				shadow_heap[shadow_count].payload = c.payload;
				bubble_up(shadow_count);
				n_push++;
				if (shadow_count > peak_count)
					peak_count = shadow_count;
			end
		end else if (shadow_count == 0) begin
			r.status = STATUS_EMPTY;
			n_empty++;
		end else begin
			r.status = STATUS_OK;
			r.out_key = shadow_heap[1].key;
			r.out_payload = shadow_heap[1].payload;
			shadow_heap[1] = shadow_heap[shadow_count];
			shadow_count--;
			bubble_down(shadow_count);
			n_pop++;
		end
		rsp_due.push_back(r);
	endfunction

	function void check_rsp(rsp_t got);
		rsp_t want;
		if (rsp_due.size() == 0) begin
			errors++;
			$display("%0t: rsp beat with none due, expected nothing, actual status %0d key %h payload %h",
				$time, got.status, got.out_key, got.out_payload);
			return;
		end
		want = rsp_due.pop_front();
		if (got.status !== want.status) begin
			errors++;
			$display("%0t: status mismatch, expected %0d actual %0d",
				$time, want.status, got.status);
		end
		if (got.out_key !== want.out_key) begin
			errors++;
			$display("%0t: out_key mismatch, expected %h actual %h",
				$time, want.out_key, got.out_key);
		end
		if (got.out_payload !== want.out_payload) begin
			errors++;
			$display("%0t: out_payload mismatch, expected %h actual %h",
				$time, want.out_payload, got.out_payload);
		end
	endfunction
endclass

module tb_min_heap_priority_queue_core;
	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned drain_wait;
	pq_scoreboard board = new();

	min_heap_priority_queue_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_min_heap_priority_queue_core: FAIL");
		$finish;
	end

	// rsp side: check each accepted beat, then pick the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				board.check_rsp(rsp);
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic cmd_t mk_cmd(logic op, logic signed [31:0] k, logic [31:0] p);
		cmd_t c;
		c.opcode = op;
		c.key = k;
		c.payload = p;
		return c;
	endfunction

	function automatic logic signed [31:0] rand_key();
		logic signed [31:0] k;
		case ($urandom_range(7))
			0: k = 32'sh7fffffff;
			1: k = 32'sh80000000;
			2, 3: begin
				// few distinct keys so ties are common
				k = $signed($urandom_range(4)) - 2;
				k = k <<< 16;
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		board.note_cmd(c);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (board.rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_capacity(value);
	endtask

	task automatic run_segment(input logic [CAP_W-1:0] cap, input int unsigned n_items,
			input int unsigned push_pct, input int unsigned s_pct, input int unsigned r_pct);
		write_capacity(cap);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				drain_results();
			send_cmd(mk_cmd(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
				rand_key(), $urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_stall_pct = 45;

		// capacity at its reset value: extremes, ties, empty pops
		send_cmd(mk_cmd(OP_POP, 32'sh7fffffff, 32'hffffffff));
		send_cmd(mk_cmd(OP_PUSH, 32'sh7fffffff, 32'hffffffff));
		send_cmd(mk_cmd(OP_PUSH, 32'sh80000000, 32'h00000000));
		send_cmd(mk_cmd(OP_PUSH, 32'sh00000000, 32'h12345678));
		send_cmd(mk_cmd(OP_PUSH, 32'sh00010000, 32'h00000001));
		send_cmd(mk_cmd(OP_PUSH, 32'sh00010000, 32'h00000002));
		send_cmd(mk_cmd(OP_PUSH, 32'shffff0000, 32'h00000003));
		send_cmd(mk_cmd(OP_PUSH, 32'sh00010000, 32'h00000004));
		repeat (7) send_cmd(mk_cmd(OP_POP, 32'sh55555555, 32'haaaaaaaa));
		send_cmd(mk_cmd(OP_POP, 32'sh00000000, 32'h00000000));

		// tiny capacity: full refusal then drain to empty
		write_capacity(11'd2);
		send_cmd(mk_cmd(OP_PUSH, 32'sh00020000, 32'h0000beef));
		send_cmd(mk_cmd(OP_PUSH, 32'shfffe0000, 32'h0000cafe));
		send_cmd(mk_cmd(OP_PUSH, 32'sh80000000, 32'hffffffff));
		repeat (3) send_cmd(mk_cmd(OP_POP, 32'sh7fffffff, 32'h00000000));

		run_segment(CAP_W'($urandom_range(1, 40)), 200, 60, 18, 45);
		// saturated limit, filled to the full depth
		run_segment(11'h7ff, 1100, 98, 45, 18);
		// zero capacity below the held count: pushes refused, deep pops
		run_segment(11'h000, 150, 15, 0, 0);
		run_segment(CAP_W'($urandom_range(0, 2047)), 80, 50, 0, 0);

		cmd_valid <= 1'b0;
		drain_wait = 0;
		while (board.rsp_due.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (30) @(posedge clk);

		$display("covered %0d pushes, %0d full refusals, %0d pops, %0d empty refusals",
			board.n_push, board.n_full, board.n_pop, board.n_empty);
		$display("heap reached %0d entries under capacities 1024, 2, small, 2047, 0, random",
			board.peak_count);
		if (board.errors == 0 && board.rsp_due.size() == 0) begin
			$display("tb_min_heap_priority_queue_core: PASS");
		end else begin
			$display("tb_min_heap_priority_queue_core: FAIL");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_engine.sv
rtl/min_heap_priority_queue_core.sv
bench/tb_min_heap_priority_queue_core.sv
